### design/x86bmt_pkg.sv
// ============================================================================
// x86bmt_pkg
// Shared types and constants for the 8088/8086 bus memory, I/O and
// interrupt target.
// ============================================================================
package x86bmt_pkg;

    // Default address reach of the two stores
    localparam int MEM_ADDR_BITS_DEF = 20;
    localparam int IO_ADDR_BITS_DEF  = 16;

    // Configuration register index (paddr[2])
    localparam logic REG_CPU_MODE = 1'b0;

    // Request function codes
    localparam logic [2:0] FUNC_BUS         = 3'd0;
    localparam logic [2:0] FUNC_RAISE_TIMER = 3'd1;
    localparam logic [2:0] FUNC_RAISE_KBD   = 3'd2;
    localparam logic [2:0] FUNC_HOST_MEM    = 3'd3;
    localparam logic [2:0] FUNC_HOST_IO     = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_MEM_RD = 3'd0;
    localparam logic [2:0] ST_MEM_WR = 3'd1;
    localparam logic [2:0] ST_IO_RD  = 3'd2;
    localparam logic [2:0] ST_IO_WR  = 3'd3;
    localparam logic [2:0] ST_VECTOR = 3'd4;
    localparam logic [2:0] ST_NONE   = 3'd5;
    localparam logic [2:0] ST_UNREC  = 3'd6;
    localparam logic [2:0] ST_HOST   = 3'd7;

    // Bus cycle codes {inta_n, io_m, dt_r}, 8088 decoding
    localparam logic [2:0] C88_MEM_RD = 3'd4;
    localparam logic [2:0] C88_MEM_WR = 3'd5;
    localparam logic [2:0] C88_IO_RD  = 3'd6;
    localparam logic [2:0] C88_IO_WR  = 3'd7;
    localparam logic [2:0] C88_ACK    = 3'd2;

    // Bus cycle codes, 8086 decoding (IO/M polarity inverted)
    localparam logic [2:0] C86_MEM_RD = 3'd6;
    localparam logic [2:0] C86_MEM_WR = 3'd7;
    localparam logic [2:0] C86_IO_RD  = 3'd4;
    localparam logic [2:0] C86_IO_WR  = 3'd5;
    localparam logic [2:0] C86_ACK    = 3'd0;

    // 8086 bank codes {bhe_n, A0}
    localparam logic [1:0] BANK_WORD = 2'd0;
    localparam logic [1:0] BANK_ODD  = 2'd1;
    localparam logic [1:0] BANK_EVEN = 2'd2;
    localparam logic [1:0] BANK_NONE = 2'd3;

    // Interrupt vectors
    localparam logic [7:0] VEC_TIMER = 8'h08;
    localparam logic [7:0] VEC_KBD   = 8'h09;

    typedef struct packed {
        logic [2:0]  func;
        logic [19:0] address;
        logic        io_m;
        logic        dt_r;
        logic        inta_n;
        logic        bhe_n;
        logic [15:0] write_data;
    } t_item;

    typedef struct packed {
        logic [15:0] read_data;
        logic        drive_low;
        logic        drive_high;
        logic        intr;
        logic [2:0]  status;
    } t_result;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MEM,
        OP_IO,
        OP_ACK,
        OP_RAISE_TIMER,
        OP_RAISE_KBD
    } t_kind;

    typedef enum logic [1:0] {
        LANE_LOW  = 2'd1,
        LANE_HIGH = 2'd2,
        LANE_WORD = 2'd3
    } t_lanes;

    typedef struct packed {
        t_kind      kind;
        logic       write;
        t_lanes     lanes;
        logic [2:0] status;
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_SECOND,
        S_FINISH,
        S_OUT
    } t_state;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;
        logic first;
        logic second;
        logic finish;
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic word;
    } t_dp_stat;

endpackage

### design/x86_bus_memory_io_target.sv
// Sequence: the accepting edge loads the request, then the first access step,
//   a second store access for a 16-bit word only, a finish step that registers
//   the result, and the result strobe. One request at a time; busy drops after
//   the strobe. Words take two accesses on the single byte-wide store port.
// Reset (i_rst_n, synchronous): controller idle, interrupt requests cleared, cpu_mode 0;
//   store contents are not initialized. Results cannot be stalled.
// ============================================================================
// x86_bus_memory_io_target
// Memory, I/O and interrupt responder for an 8088/8086 bus, with an APB
// configuration register selecting 8-bit or 16-bit bus decoding.
// ============================================================================
module x86_bus_memory_io_target #(
    parameter int MEM_ADDR_BITS = x86bmt_pkg::MEM_ADDR_BITS_DEF,
    parameter int IO_ADDR_BITS  = x86bmt_pkg::IO_ADDR_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                start,
    output logic                busy,
    input  x86bmt_pkg::t_item   i_item,
    // result channel
    output logic                o_done,
    output x86bmt_pkg::t_result o_result,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import x86bmt_pkg::*;

    logic     r_cpu_mode;
    t_cmd     cmd;
    t_dp_stat stat;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_mode <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == REG_CPU_MODE) begin
            r_cpu_mode <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CPU_MODE) ? {31'd0, r_cpu_mode} : 32'd0;

    x86bmt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    x86bmt_dp #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS),
        .IO_ADDR_BITS  (IO_ADDR_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cpu_mode (r_cpu_mode),
        .i_item     (i_item),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_result   (o_result)
    );

endmodule

### design/x86bmt_ram.sv
// ============================================================================
// x86bmt_ram
// Generic single-port RAM, read-before-write, registered read data.
// ============================================================================
module x86bmt_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    // Single access port
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/x86bmt_ctrl.sv
// ============================================================================
// x86bmt_ctrl
// Request sequencer: load, one or two store accesses, finish, result strobe.
// ============================================================================
module x86bmt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  x86bmt_pkg::t_dp_stat i_stat,
    output x86bmt_pkg::t_cmd    o_cmd,
    output logic                o_busy,
    output logic                o_done
);
    import x86bmt_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_FIRST;
            end
            S_FIRST: begin
                n_state = i_stat.word ? S_SECOND : S_FINISH;
            end
            S_SECOND: n_state = S_FINISH;
            S_FINISH: n_state = S_OUT;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        o_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_FIRST:  o_cmd.first  = 1'b1;
            S_SECOND: o_cmd.second = 1'b1;
            S_FINISH: o_cmd.finish = 1'b1;
            S_OUT:    o_done       = 1'b1;
            default:  o_busy       = 1'b1;
        endcase
    end

endmodule

### design/x86bmt_dp.sv
// ============================================================================
// x86bmt_dp
// Datapath: bus cycle decode, memory and I/O byte stores, interrupt
// request flags and the result register.
// ============================================================================
module x86bmt_dp #(
    parameter int MEM_ADDR_BITS = x86bmt_pkg::MEM_ADDR_BITS_DEF,
    parameter int IO_ADDR_BITS  = x86bmt_pkg::IO_ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cpu_mode,
    input  x86bmt_pkg::t_item    i_item,
    input  x86bmt_pkg::t_cmd     i_cmd,
    output x86bmt_pkg::t_dp_stat o_stat,
    output x86bmt_pkg::t_result  o_result
);
    import x86bmt_pkg::*;

    t_op         r_op;
    t_op         n_op;
    logic [19:0] r_addr;
    logic [15:0] r_wd;
    logic [7:0]  r_byte0;
    logic [15:0] r_rd;
    logic        r_dl;
    logic        r_dh;
    logic [2:0]  r_status;
    logic        r_timer;
    logic        r_kbd;

    logic [2:0]  code;
    logic [1:0]  bank;

    logic [MEM_ADDR_BITS-1:0] mem_addr;
    logic [IO_ADDR_BITS-1:0]  io_addr;
    logic        acc;
    logic        mem_en;
    logic        io_en;
    logic [7:0]  wbyte;
    logic [7:0]  mem_rdata;
    logic [7:0]  io_rdata;
    logic [7:0]  rd_byte;

    assign code = {i_item.inta_n, i_item.io_m, i_item.dt_r};
    assign bank = {i_item.bhe_n, i_item.address[0]};

    // Request decode
    always_comb begin
        n_op.kind   = OP_NONE;
        n_op.write  = 1'b0;
        n_op.lanes  = LANE_LOW;
        n_op.status = ST_UNREC;
        case (i_item.func)
            FUNC_RAISE_TIMER: begin
                n_op.kind   = OP_RAISE_TIMER;
                n_op.status = ST_HOST;
            end
            FUNC_RAISE_KBD: begin
                n_op.kind   = OP_RAISE_KBD;
                n_op.status = ST_HOST;
            end
            FUNC_HOST_MEM: begin
                n_op.kind   = OP_MEM;
                n_op.write  = 1'b1;
                n_op.status = ST_HOST;
            end
            FUNC_HOST_IO: begin
                n_op.kind   = OP_IO;
                n_op.write  = 1'b1;
                n_op.status = ST_HOST;
            end
            FUNC_BUS: begin
                if (!i_cpu_mode) begin
                    // 8-bit bus: low lane only
                    case (code)
                        C88_MEM_RD: begin
                            n_op.kind = OP_MEM; n_op.status = ST_MEM_RD;
                        end
                        C88_MEM_WR: begin
                            n_op.kind = OP_MEM; n_op.write = 1'b1; n_op.status = ST_MEM_WR;
                        end
                        C88_IO_RD: begin
                            n_op.kind = OP_IO; n_op.status = ST_IO_RD;
                        end
                        C88_IO_WR: begin
                            n_op.kind = OP_IO; n_op.write = 1'b1; n_op.status = ST_IO_WR;
                        end
                        C88_ACK: n_op.kind = OP_ACK;
                        default: n_op.kind = OP_NONE;
                    endcase
                end else if (bank == BANK_WORD && code == C86_ACK) begin
                    n_op.kind = OP_ACK;
                end else if (bank != BANK_NONE) begin
                    // 16-bit bus: lanes follow BHE and A0
                    case (bank)
                        BANK_WORD: n_op.lanes = LANE_WORD;
                        BANK_ODD:  n_op.lanes = LANE_HIGH;
                        default:   n_op.lanes = LANE_LOW;
                    endcase
                    case (code)
                        C86_MEM_RD: begin
                            n_op.kind = OP_MEM; n_op.status = ST_MEM_RD;
                        end
                        C86_MEM_WR: begin
                            n_op.kind = OP_MEM; n_op.write = 1'b1; n_op.status = ST_MEM_WR;
                        end
                        C86_IO_RD: begin
                            n_op.kind = OP_IO; n_op.status = ST_IO_RD;
                        end
                        C86_IO_WR: begin
                            n_op.kind = OP_IO; n_op.write = 1'b1; n_op.status = ST_IO_WR;
                        end
                        default: n_op.kind = OP_NONE;
                    endcase
                end
            end
            default: n_op.kind = OP_NONE;
        endcase
    end

    // Request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= n_op;
            r_addr <= i_item.address;
            r_wd   <= i_item.write_data;
        end
    end

    assign o_stat.word = (r_op.kind == OP_MEM || r_op.kind == OP_IO)
                         && r_op.lanes == LANE_WORD;

    // Store access: first byte at the address, second byte wraps in its space
    assign acc    = i_cmd.first || i_cmd.second;
    assign mem_en = acc && r_op.kind == OP_MEM;
    assign io_en  = acc && r_op.kind == OP_IO;
    assign mem_addr = r_addr[MEM_ADDR_BITS-1:0] + {{(MEM_ADDR_BITS-1){1'b0}}, i_cmd.second};
    assign io_addr  = r_addr[IO_ADDR_BITS-1:0] + {{(IO_ADDR_BITS-1){1'b0}}, i_cmd.second};
    assign wbyte  = (i_cmd.second || r_op.lanes == LANE_HIGH) ? r_wd[15:8] : r_wd[7:0];

    x86bmt_ram #(
        .DATA_W (8),
        .ADDR_W (MEM_ADDR_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (r_op.write),
        .i_addr  (mem_addr),
        .i_wdata (wbyte),
        .o_rdata (mem_rdata)
    );

    x86bmt_ram #(
        .DATA_W (8),
        .ADDR_W (IO_ADDR_BITS)
    ) u_io (
        .i_clk   (i_clk),
        .i_en    (io_en),
        .i_we    (r_op.write),
        .i_addr  (io_addr),
        .i_wdata (wbyte),
        .o_rdata (io_rdata)
    );

    assign rd_byte = (r_op.kind == OP_IO) ? io_rdata : mem_rdata;

    // Low byte of a word read arrives during the second access
    always_ff @(posedge i_clk) begin
        if (i_cmd.second) r_byte0 <= rd_byte;
    end

    // Result register and interrupt request flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= 1'b0;
            r_kbd   <= 1'b0;
        end else if (i_cmd.finish) begin
            r_rd     <= '0;
            r_dl     <= 1'b0;
            r_dh     <= 1'b0;
            r_status <= r_op.status;
            case (r_op.kind)
                OP_MEM, OP_IO: begin
                    if (!r_op.write) begin
                        case (r_op.lanes)
                            LANE_WORD: begin
                                r_rd <= {rd_byte, r_byte0};
                                r_dl <= 1'b1;
                                r_dh <= 1'b1;
                            end
                            LANE_HIGH: begin
                                r_rd <= {rd_byte, 8'h00};
                                r_dh <= 1'b1;
                            end
                            default: begin
                                r_rd <= {8'h00, rd_byte};
                                r_dl <= 1'b1;
                            end
                        endcase
                    end
                end
                OP_ACK: begin
                    // Timer wins; only the served request clears
                    if (r_timer) begin
                        r_rd     <= {8'h00, VEC_TIMER};
                        r_dl     <= 1'b1;
                        r_status <= ST_VECTOR;
                        r_timer  <= 1'b0;
                    end else if (r_kbd) begin
                        r_rd     <= {8'h00, VEC_KBD};
                        r_dl     <= 1'b1;
                        r_status <= ST_VECTOR;
                        r_kbd    <= 1'b0;
                    end else begin
                        r_status <= ST_NONE;
                    end
                end
                OP_RAISE_TIMER: r_timer <= 1'b1;
                OP_RAISE_KBD:   r_kbd   <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_result.read_data  = r_rd;
    assign o_result.drive_low  = r_dl;
    assign o_result.drive_high = r_dh;
    assign o_result.intr       = r_timer | r_kbd;
    assign o_result.status     = r_status;

endmodule

### design/x86bmt_checker.sv
// ============================================================================
// x86bmt_checker
// Port-level checks of request/result sequencing and result encoding.
// ============================================================================
module x86bmt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input x86bmt_pkg::t_result o_result
);
    import x86bmt_pkg::*;

    // An accepted request holds the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("busy not raised after accept");

    // A result only ends a request in progress
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("result strobe while idle");

    // Block is free again right after the strobe
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy && !o_done) else $error("not idle after result");

    // Write results drive no lane
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_result.status == ST_MEM_WR || o_result.status == ST_IO_WR)
        |-> !o_result.drive_low && !o_result.drive_high && o_result.read_data == 16'd0)
        else $error("write result drives a lane");

    // Nothing pending on acknowledge means intr is low
    a_none_intr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status == ST_NONE |-> !o_result.intr)
        else $error("intr high with no request pending");

endmodule

bind x86_bus_memory_io_target x86bmt_checker u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
